FILE: sv/snk_pkg.sv
// shared types, constants and defaults for the sort key normalizer
`default_nettype none
package snk_pkg;

  localparam int RECORD_BYTES_DEF = 4096;
  localparam int KEY_FIELDS_DEF   = 8;
  localparam int SUFFIX_BYTES_DEF = 9;

  localparam int IDX_W     = 13;
  localparam int CFG_W     = 22;
  localparam int CFG_IDX_W = 4;
  localparam int START_W   = 12;
  localparam int LEN_W     = 8;
  localparam int BASE_W    = 12;

  localparam logic OP_STORE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] INV_MASK = 8'hff;
  localparam logic [7:0] NEG_LEAD = 8'hfe ^ INV_MASK;

  typedef enum logic [1:0] {
    PART_KEY    = 2'd0,
    PART_SUFFIX = 2'd1,
    PART_RECORD = 2'd2,
    PART_NONE   = 2'd3
  } part_t;

  typedef struct packed {
    logic               numeric;
    logic               descending;
    logic [LEN_W-1:0]   len;
    logic [START_W-1:0] start;
  } key_desc_t;

  typedef struct packed {
    logic               store;
    part_t              part;
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   pos;
    logic               descending;
    logic               numeric;
    logic [IDX_W-1:0]   raw;
  } dec_t;

  typedef struct packed {
    part_t part;
    logic  descending;
    logic  numeric;
    logic  pos_zero;
    logic  first_oor;
    logic  key_oor;
  } shp_ctl_t;

endpackage
`default_nettype wire

FILE: sv/sort_key_normalizer.sv
// top level of the sort key normalizer: config registers and three-stage pipeline
//
//   channel  | ports                                   | direction
//   input    | in_valid in_stall in_op in_index in_byte_in | item in
//   output   | out_valid out_stall out_byte_out out_part   | item out
//   config   | cfg_we cfg_index cfg_data                   | register write
//
// one item per cycle unless out_stall holds a result
// stage 1 locates the offset, stage 2 reads the record memory, stage 3 shapes the byte
// an output held by out_stall freezes every stage and raises in_stall in the same cycle
// reset clears valid bits and key field registers; record memory is not cleared
`default_nettype none
module sort_key_normalizer #(
  parameter int RECORD_BYTES = snk_pkg::RECORD_BYTES_DEF,
  parameter int KEY_FIELDS   = snk_pkg::KEY_FIELDS_DEF,
  parameter int SUFFIX_BYTES = snk_pkg::SUFFIX_BYTES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         in_op,
  input  wire logic [snk_pkg::IDX_W-1:0]    in_index,
  input  wire logic [7:0]                   in_byte_in,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic      [7:0]                   out_byte_out,
  output logic      [1:0]                   out_part,
  input  wire logic                         cfg_we,
  input  wire logic [snk_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [snk_pkg::CFG_W-1:0]    cfg_data
);

  localparam int AW = $clog2(RECORD_BYTES);
  localparam logic [snk_pkg::IDX_W-1:0] REC_LIM = snk_pkg::IDX_W'(RECORD_BYTES);

  snk_pkg::key_desc_t cfg_r [KEY_FIELDS];

  always_ff @(posedge clk) begin
    for (int f = 0; f < KEY_FIELDS; f++) begin
      if (!rst_n) begin
        cfg_r[f] <= '0;
      end else if (cfg_we && (cfg_index == snk_pkg::CFG_IDX_W'(f))) begin
        cfg_r[f] <= snk_pkg::key_desc_t'(cfg_data);
      end
    end
  end

  logic adv;
  logic out_valid_r;
  assign adv = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  // stage 1: decode
  snk_pkg::dec_t dec_nxt;
  snk_pkg::dec_t s1_dec_r;
  logic          s1_valid_r;
  logic [snk_pkg::IDX_W-1:0] s1_index_r;
  logic [7:0]    s1_byte_r;

  snk_decode #(
    .RECORD_BYTES(RECORD_BYTES),
    .KEY_FIELDS  (KEY_FIELDS),
    .SUFFIX_BYTES(SUFFIX_BYTES)
  ) u_decode (
    .op   (in_op),
    .index(in_index),
    .desc (cfg_r),
    .dec  (dec_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_dec_r   <= dec_nxt;
      s1_index_r <= in_index;
      s1_byte_r  <= in_byte_in;
    end
  end

  // stage 2: memory access
  logic [snk_pkg::IDX_W-1:0] key_addr;
  logic                      wr_en;
  logic [AW-1:0]             rd_b_addr;
  logic [7:0]                first_byte;
  logic [7:0]                data_byte;
  snk_pkg::shp_ctl_t         ctl_nxt;
  snk_pkg::shp_ctl_t         s2_ctl_r;
  logic                      s2_valid_r;

  assign key_addr = {1'b0, s1_dec_r.start} + snk_pkg::IDX_W'(s1_dec_r.pos);
  assign wr_en = adv && s1_valid_r && s1_dec_r.store && (s1_index_r < REC_LIM);
  assign rd_b_addr = (s1_dec_r.part == snk_pkg::PART_KEY) ? key_addr[AW-1:0]
                                                         : s1_dec_r.raw[AW-1:0];

  always_comb begin
    ctl_nxt.part       = s1_dec_r.part;
    ctl_nxt.descending = s1_dec_r.descending;
    ctl_nxt.numeric    = s1_dec_r.numeric;
    ctl_nxt.pos_zero   = (s1_dec_r.pos == '0);
    ctl_nxt.first_oor  = ({1'b0, s1_dec_r.start} >= REC_LIM);
    ctl_nxt.key_oor    = (key_addr >= REC_LIM);
  end

  snk_store #(
    .RECORD_BYTES(RECORD_BYTES)
  ) u_store (
    .clk      (clk),
    .en       (adv),
    .wr_en    (wr_en),
    .wr_addr  (s1_index_r[AW-1:0]),
    .wr_data  (s1_byte_r),
    .rd_a_addr(s1_dec_r.start[AW-1:0]),
    .rd_b_addr(rd_b_addr),
    .rd_a_data(first_byte),
    .rd_b_data(data_byte)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_ctl_r <= ctl_nxt;
    end
  end

  // stage 3: shaping into the output register
  logic [7:0]    byte_nxt;
  logic [7:0]    out_byte_r;
  snk_pkg::part_t out_part_r;

  snk_shape u_shape (
    .ctl       (s2_ctl_r),
    .first_byte(first_byte),
    .data_byte (data_byte),
    .byte_out  (byte_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_byte_r <= byte_nxt;
      out_part_r <= s2_ctl_r.part;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_byte_out = out_byte_r;
  assign out_part     = 2'(out_part_r);

endmodule
`default_nettype wire

FILE: sv/snk_decode.sv
// locates a pseudo-record offset: key field, suffix, record data or past end
`default_nettype none
module snk_decode #(
  parameter int RECORD_BYTES = snk_pkg::RECORD_BYTES_DEF,
  parameter int KEY_FIELDS   = snk_pkg::KEY_FIELDS_DEF,
  parameter int SUFFIX_BYTES = snk_pkg::SUFFIX_BYTES_DEF
) (
  input  wire logic                     op,
  input  wire logic [snk_pkg::IDX_W-1:0] index,
  input  wire snk_pkg::key_desc_t       desc [KEY_FIELDS],
  output snk_pkg::dec_t                 dec
);

  localparam logic [snk_pkg::IDX_W-1:0] REC_LIM = snk_pkg::IDX_W'(RECORD_BYTES);

  always_comb begin
    logic [snk_pkg::BASE_W-1:0] acc;
    logic [snk_pkg::BASE_W-1:0] nxt_end;
    logic [snk_pkg::IDX_W-1:0]  sfx_end;
    logic                       found;
    acc = '0;
    found = 1'b0;
    dec = '0;
    dec.store = (op == snk_pkg::OP_STORE);
    // ends of the fields are cumulative, so the first end above the offset wins
    for (int f = 0; f < KEY_FIELDS; f++) begin
      nxt_end = acc + snk_pkg::BASE_W'(desc[f].len);
      if (!found && (index < {1'b0, nxt_end})) begin
        found = 1'b1;
        dec.start = desc[f].start;
        dec.descending = desc[f].descending;
        dec.numeric = desc[f].numeric;
        dec.pos = snk_pkg::LEN_W'(index - {1'b0, acc});
      end
      acc = nxt_end;
    end
    sfx_end = {1'b0, acc} + snk_pkg::IDX_W'(SUFFIX_BYTES);
    dec.raw = index - sfx_end;
    if (dec.store) begin
      dec.part = snk_pkg::PART_NONE;
    end else if (found) begin
      dec.part = snk_pkg::PART_KEY;
    end else if (index < sfx_end) begin
      dec.part = snk_pkg::PART_SUFFIX;
    end else if (dec.raw < REC_LIM) begin
      dec.part = snk_pkg::PART_RECORD;
    end else begin
      dec.part = snk_pkg::PART_NONE;
    end
  end

endmodule
`default_nettype wire

FILE: sv/snk_store.sv
// record byte memory, one write port and two registered read ports
`default_nettype none
module snk_store #(
  parameter  int RECORD_BYTES = snk_pkg::RECORD_BYTES_DEF,
  localparam int AW = $clog2(RECORD_BYTES)
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  input  wire logic [AW-1:0] rd_a_addr,
  input  wire logic [AW-1:0] rd_b_addr,
  output logic      [7:0]    rd_a_data,
  output logic      [7:0]    rd_b_data
);

  logic [7:0] mem [RECORD_BYTES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rd_a_data <= mem[rd_a_addr];
      rd_b_data <= mem[rd_b_addr];
    end
  end

endmodule
`default_nettype wire

FILE: sv/snk_shape.sv
// applies the numeric sign and descending rules to a fetched byte
`default_nettype none
module snk_shape (
  input  wire snk_pkg::shp_ctl_t ctl,
  input  wire logic [7:0]        first_byte,
  input  wire logic [7:0]        data_byte,
  output logic      [7:0]        byte_out
);

  always_comb begin
    logic [7:0] lead;
    logic [7:0] b;
    lead = ctl.first_oor ? 8'h00 : first_byte;
    b = ctl.key_oor ? 8'h00 : data_byte;
    if (ctl.numeric) begin
      if (lead == snk_pkg::CH_SPACE) begin
        if (ctl.pos_zero) begin
          b = snk_pkg::CH_PLUS;
        end
      end else if (lead == snk_pkg::CH_MINUS) begin
        b = ctl.pos_zero ? snk_pkg::NEG_LEAD : (b ^ snk_pkg::INV_MASK);
      end
    end
    if (ctl.descending) begin
      b = b ^ snk_pkg::INV_MASK;
    end
    case (ctl.part)
      snk_pkg::PART_KEY:    byte_out = b;
      snk_pkg::PART_SUFFIX: byte_out = snk_pkg::CH_ZERO;
      snk_pkg::PART_RECORD: byte_out = data_byte;
      default:              byte_out = 8'h00;
    endcase
  end

endmodule
`default_nettype wire

FILE: sv/snk_checker.sv
// port-level checker for the sort key normalizer and its bind
`default_nettype none
module snk_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       in_op,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_byte_out,
  input wire logic [1:0] out_part
);

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_byte_out) && $stable(out_part))
    else $error("output payload changed while stalled");

  // input backpressure comes only from a held result
  a_in_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("in_stall without a stalled result");

  // a store item, with out_stall low behind it, comes out as zero, past-end part
  a_store_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_op == snk_pkg::OP_STORE) ##1 !out_stall ##1 !out_stall
    |=> out_valid && out_part == 2'(snk_pkg::PART_NONE) && out_byte_out == 8'h00)
    else $error("store item result wrong");

  a_suffix_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_part == 2'(snk_pkg::PART_SUFFIX) |-> out_byte_out == snk_pkg::CH_ZERO)
    else $error("suffix byte is not ascii zero");

endmodule

bind sort_key_normalizer snk_checker u_snk_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .in_op       (in_op),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_byte_out(out_byte_out),
  .out_part    (out_part)
);
`default_nettype wire

FILE: tb/sv/tb.sv
// self-checking testbench for the sort key normalizer: directed table, then random phases
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import snk_pkg::*;

  localparam int ITEMS_TOTAL  = 1650;
  localparam int PHASE_ITEMS  = 120;
  localparam int DRAIN_CYCLES = 10;
  localparam int IDLE_LIMIT   = 2000;
  localparam int IDX_MAX      = (1 << IDX_W) - 1;
  localparam int DIR_ROW_CNT  = 25;

  typedef enum logic [0:0] {
    ROW_ITEM   = 1'b0,
    ROW_KEYSET = 1'b1
  } row_kind_t;

  typedef struct packed {
    row_kind_t        kind;
    logic             op;
    logic [IDX_W-1:0] idx;
    logic [7:0]       data;
    logic             typed;
    logic [7:0]       exp_byte;
    part_t            exp_part;
  } dir_row_t;

  typedef struct packed {
    logic [7:0] byte_val;
    part_t      part;
  } key_out_t;

  // key fields used by the directed rows after the keyset row
  localparam logic [CFG_W-1:0] DIR_FIELDS [8] = '{
    {1'b1, 1'b0, 8'd2, 12'd16},    // numeric, leading space
    {1'b1, 1'b1, 8'd0, 12'd48},    // zero length, skipped despite flags
    {1'b1, 1'b0, 8'd2, 12'd32},    // numeric, leading minus
    {1'b0, 1'b1, 8'd1, 12'd48},    // descending
    {1'b1, 1'b1, 8'd3, 12'd4094},  // runs past the end of the record
    {CFG_W{1'b0}},
    {CFG_W{1'b0}},
    {CFG_W{1'b0}}
  };

  localparam dir_row_t DIR_ROWS [DIR_ROW_CNT] = '{
    '{ROW_ITEM,   OP_READ,  13'd0,    8'h00, 1'b1, CH_ZERO, PART_SUFFIX},
    '{ROW_ITEM,   OP_STORE, 13'd0,    8'hff, 1'b1, 8'h00,   PART_NONE},
    '{ROW_ITEM,   OP_STORE, 13'd4095, 8'h00, 1'b1, 8'h00,   PART_NONE},
    '{ROW_ITEM,   OP_STORE, 13'd8191, 8'ha5, 1'b1, 8'h00,   PART_NONE},
    '{ROW_ITEM,   OP_READ,  13'd9,    8'h00, 1'b1, 8'hff,   PART_RECORD},
    '{ROW_ITEM,   OP_READ,  13'd4104, 8'h00, 1'b1, 8'h00,   PART_RECORD},
    '{ROW_ITEM,   OP_READ,  13'd4105, 8'h00, 1'b1, 8'h00,   PART_NONE},
    '{ROW_ITEM,   OP_READ,  13'd8191, 8'hff, 1'b1, 8'h00,   PART_NONE},
    '{ROW_ITEM,   OP_STORE, 13'd16,   8'h20, 1'b1, 8'h00,   PART_NONE},
    '{ROW_ITEM,   OP_STORE, 13'd17,   8'h31, 1'b1, 8'h00,   PART_NONE},
    '{ROW_ITEM,   OP_STORE, 13'd32,   8'h2d, 1'b1, 8'h00,   PART_NONE},
    '{ROW_ITEM,   OP_STORE, 13'd33,   8'h12, 1'b1, 8'h00,   PART_NONE},
    '{ROW_ITEM,   OP_STORE, 13'd48,   8'h41, 1'b1, 8'h00,   PART_NONE},
    '{ROW_ITEM,   OP_STORE, 13'd4094, 8'h7e, 1'b1, 8'h00,   PART_NONE},
    '{ROW_KEYSET, OP_READ,  13'd0,    8'h00, 1'b0, 8'h00,   PART_NONE},
    '{ROW_ITEM,   OP_READ,  13'd0,    8'h00, 1'b0, 8'h00,   PART_NONE},
    '{ROW_ITEM,   OP_READ,  13'd1,    8'h00, 1'b0, 8'h00,   PART_NONE},
    '{ROW_ITEM,   OP_READ,  13'd2,    8'h00, 1'b0, 8'h00,   PART_NONE},
    '{ROW_ITEM,   OP_READ,  13'd3,    8'h00, 1'b0, 8'h00,   PART_NONE},
    '{ROW_ITEM,   OP_READ,  13'd4,    8'h00, 1'b0, 8'h00,   PART_NONE},
    '{ROW_ITEM,   OP_READ,  13'd5,    8'h00, 1'b0, 8'h00,   PART_NONE},
    '{ROW_ITEM,   OP_READ,  13'd7,    8'h00, 1'b0, 8'h00,   PART_NONE},
    '{ROW_ITEM,   OP_READ,  13'd8,    8'h00, 1'b0, 8'h00,   PART_NONE},
    '{ROW_ITEM,   OP_READ,  13'd16,   8'h00, 1'b0, 8'h00,   PART_NONE},
    '{ROW_ITEM,   OP_READ,  13'd17,   8'h00, 1'b0, 8'h00,   PART_NONE}
  };

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic             in_op;
  logic [IDX_W-1:0] in_index;
  logic [7:0]       in_byte_in;
  logic             out_valid;
  logic             out_stall;
  logic [7:0]       out_byte_out;
  logic [1:0]       out_part;
  logic             cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  key_desc_t        key_cfg [KEY_FIELDS_DEF];
  logic [CFG_W-1:0] staged_cfg [KEY_FIELDS_DEF];
  logic [7:0]       rec_mem [RECORD_BYTES_DEF];
  bit               rec_seen [RECORD_BYTES_DEF];
  key_out_t         key_out_q [$];
  int               item_cnt;
  int               mismatches;
  int               idle_cycles;
  bit               calm;

  sort_key_normalizer dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_index     (in_index),
    .in_byte_in   (in_byte_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte_out (out_byte_out),
    .out_part     (out_part),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // where a pseudo-record offset lands under the current key fields
  function automatic void locate(input int ix, output part_t pt, output int fld,
                                 output int off);
    int base;
    int len;
    base = 0;
    pt = PART_NONE;
    fld = 0;
    off = 0;
    for (int f = 0; f < KEY_FIELDS_DEF; f++) begin
      len = key_cfg[f].len;
      if (ix < base + len) begin
        pt = PART_KEY;
        fld = f;
        off = ix - base;
        return;
      end
      base += len;
    end
    if (ix < base + SUFFIX_BYTES_DEF) begin
      pt = PART_SUFFIX;
      return;
    end
    base += SUFFIX_BYTES_DEF;
    if (ix < base + RECORD_BYTES_DEF) begin
      pt = PART_RECORD;
      off = ix - base;
    end
  endfunction

  function automatic key_out_t normalize_item(input logic op, input logic [IDX_W-1:0] idx,
                                              input logic [7:0] data);
    key_out_t  r;
    part_t     pt;
    int        fld;
    int        off;
    int        addr;
    key_desc_t d;
    logic [7:0] first;
    logic [7:0] b;
    r.byte_val = 8'h00;
    r.part = PART_NONE;
    if (op == OP_STORE) begin
      if (idx < RECORD_BYTES_DEF) begin
        rec_mem[idx] = data;
        rec_seen[idx] = 1'b1;
      end
      return r;
    end
    locate(int'(idx), pt, fld, off);
    r.part = pt;
    case (pt)
      PART_KEY: begin
        d = key_cfg[fld];
        addr = int'(d.start) + off;
        first = rec_mem[d.start];
        // key bytes past the record read as zero before shaping
        b = (addr < RECORD_BYTES_DEF) ? rec_mem[addr] : 8'h00;
        if (d.numeric) begin
          if (first == CH_SPACE) begin
            if (off == 0) b = CH_PLUS;
          end else if (first == CH_MINUS) begin
            b = (off == 0) ? NEG_LEAD : ~b;
          end
        end
        if (d.descending) b = ~b;
        r.byte_val = b;
      end
      PART_SUFFIX: r.byte_val = CH_ZERO;
      PART_RECORD: r.byte_val = rec_mem[off];
      default:     r.byte_val = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] lead_byte();
    int pick;
    pick = $urandom_range(0, 2);
    if (pick == 0) return CH_SPACE;
    if (pick == 1) return CH_MINUS;
    return 8'($urandom);
  endfunction

  task automatic send_item(input logic op, input logic [IDX_W-1:0] idx, input logic [7:0] data,
                           input logic typed = 1'b0, input logic [7:0] t_byte = 8'h00,
                           input part_t t_part = PART_NONE);
    int       gap;
    bit       taken;
    key_out_t r;
    gap = calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_index <= idx;
    in_byte_in <= data;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    r = normalize_item(op, idx, data);
    if (typed) begin
      r.byte_val = t_byte;
      r.part = t_part;
    end
    key_out_q.push_back(r);
    // stores past the record are ignored by the block
    if (op == OP_READ || idx < RECORD_BYTES_DEF) item_cnt++;
  endtask

  // stores any record byte the read depends on before issuing it
  task automatic read_pseudo(input int ix);
    part_t pt;
    int    fld;
    int    off;
    int    addr;
    locate(ix, pt, fld, off);
    if (pt == PART_KEY) begin
      addr = key_cfg[fld].start;
      if (!rec_seen[addr]) send_item(OP_STORE, IDX_W'(addr), lead_byte());
      addr += off;
      if (addr < RECORD_BYTES_DEF && !rec_seen[addr])
        send_item(OP_STORE, IDX_W'(addr), 8'($urandom));
    end else if (pt == PART_RECORD && !rec_seen[off]) begin
      send_item(OP_STORE, IDX_W'(off), 8'($urandom));
    end
    send_item(OP_READ, IDX_W'(ix), 8'($urandom));
  endtask

  // waits for the pipeline to drain, then loads staged_cfg into the key field registers
  task automatic program_fields();
    in_valid <= 1'b0;
    while (key_out_q.size() != 0) @(posedge clk);
    for (int i = 0; i < KEY_FIELDS_DEF; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data <= staged_cfg[i];
      @(posedge clk);
      key_cfg[i] = staged_cfg[i];
    end
    // register slots past the key fields do nothing
    cfg_index <= CFG_IDX_W'($urandom_range(KEY_FIELDS_DEF, (1 << CFG_IDX_W) - 1));
    cfg_data <= CFG_W'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : result_check
    int         hold;
    bit         taken;
    logic [7:0] got_byte;
    logic [1:0] got_part;
    key_out_t   want;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      hold = calm ? 0 : $urandom_range(0, 7);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do begin
        @(negedge clk);
        taken = (out_valid === 1'b1);
        got_byte = out_byte_out;
        got_part = out_part;
        @(posedge clk);
      end while (!taken);
      if (key_out_q.size() == 0) begin
        $display("%0t: item with nothing expected: byte_out %h part %0d",
                 $time, got_byte, got_part);
        mismatches++;
      end else begin
        want = key_out_q.pop_front();
        if (got_byte !== want.byte_val) begin
          $display("%0t: byte_out expected %h actual %h", $time, want.byte_val, got_byte);
          mismatches++;
        end
        if (got_part !== want.part) begin
          $display("%0t: part expected %0d actual %0d", $time, want.part, got_part);
          mismatches++;
        end
      end
    end
  end

  initial begin : watchdog
    idle_cycles = 0;
    wait (rst_n === 1'b1);
    while (idle_cycles < IDLE_LIMIT) begin
      @(negedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("sort_key_normalizer test failed");
    $finish;
  end

  initial begin : stimulus
    key_desc_t d;
    int        key_total;
    int        pick;
    int        reg_pick;
    int        lo;
    int        ix;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = OP_STORE;
    in_index = '0;
    in_byte_in = 8'h00;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    calm = 1'b0;
    item_cnt = 0;
    mismatches = 0;
    for (int f = 0; f < KEY_FIELDS_DEF; f++) key_cfg[f] = '0;
    for (int a = 0; a < RECORD_BYTES_DEF; a++) rec_seen[a] = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < DIR_ROW_CNT; r++) begin
      if (DIR_ROWS[r].kind == ROW_KEYSET) begin
        for (int f = 0; f < KEY_FIELDS_DEF; f++) staged_cfg[f] = DIR_FIELDS[f];
        program_fields();
      end else begin
        send_item(DIR_ROWS[r].op, DIR_ROWS[r].idx, DIR_ROWS[r].data, DIR_ROWS[r].typed,
                  DIR_ROWS[r].exp_byte, DIR_ROWS[r].exp_part);
      end
    end

    for (int ph = 0; item_cnt < ITEMS_TOTAL; ph++) begin
      calm = ($urandom_range(0, 3) == 0);
      for (int f = 0; f < KEY_FIELDS_DEF; f++) begin
        if (ph == 0) begin
          staged_cfg[f] = '1;
        end else if (ph == 1) begin
          staged_cfg[f] = '0;
        end else begin
          // bias starts toward the top so fields run off the record
          d.start = ($urandom_range(0, 3) == 0) ? START_W'($urandom_range(3840, 4095))
                                                : START_W'($urandom);
          pick = $urandom_range(0, 9);
          if (pick < 2) d.len = '0;
          else if (pick < 6) d.len = LEN_W'($urandom_range(1, 8));
          else d.len = LEN_W'($urandom);
          d.descending = 1'($urandom);
          d.numeric = 1'($urandom);
          staged_cfg[f] = d;
        end
      end
      program_fields();
      key_total = 0;
      for (int f = 0; f < KEY_FIELDS_DEF; f++) key_total += key_cfg[f].len;

      for (int k = 0; k < PHASE_ITEMS && item_cnt < ITEMS_TOTAL; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
          send_item(OP_STORE, IDX_W'($urandom), 8'($urandom));
        end else if (pick < 22) begin
          // flip the sign byte of some field
          send_item(OP_STORE, IDX_W'(key_cfg[$urandom_range(0, KEY_FIELDS_DEF - 1)].start),
                    lead_byte());
        end else begin
          reg_pick = $urandom_range(0, 99);
          lo = key_total + SUFFIX_BYTES_DEF + RECORD_BYTES_DEF;
          if (reg_pick < 45 && key_total > 0) ix = $urandom_range(0, key_total - 1);
          else if (reg_pick < 55) ix = key_total + $urandom_range(0, SUFFIX_BYTES_DEF - 1);
          else if (reg_pick < 75)
            ix = key_total + SUFFIX_BYTES_DEF + $urandom_range(0, RECORD_BYTES_DEF - 1);
          else if (reg_pick < 82) ix = $urandom_range(lo, IDX_MAX);
          else ix = $urandom_range(0, IDX_MAX);
          read_pseudo(ix);
        end
      end
    end

    in_valid <= 1'b0;
    while (key_out_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("sort_key_normalizer test passed");
    end else begin
      $display("sort_key_normalizer test failed");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/snk_pkg.sv
sv/snk_decode.sv
sv/snk_store.sv
sv/snk_shape.sv
sv/sort_key_normalizer.sv
sv/snk_checker.sv
tb/sv/tb.sv
